FILE: src/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants and types for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_A = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_B = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_CAL_C = 4'd3;
	localparam int CFG_DATA_W = 48;

	// temperature: centi = (fine * 5 + 128) >> 8
	localparam int TEMP_SCALE = 5;
	localparam int TEMP_ROUND = 128;
	localparam int TEMP_MIN   = -32768;
	localparam int TEMP_MAX   = 32767;

	// pressure polynomial constants
	localparam int FINE_OFFSET = 128000;
	localparam int PRESS_BASE  = 1048576;
	localparam int PRESS_SCALE = 3125;
	localparam int PRESS_MAX   = 33554431;
	localparam logic [63:0] DEN_BIAS = 64'h0000_8000_0000_0000;

	// divider geometry
	localparam int DIV_NUM_W     = 64;
	localparam int DIV_DEN_W     = 31;
	localparam int DIV_STEP_BITS = 4;

	// sideband that rides through the divider
	typedef struct packed {
		logic        neg;
		logic        div_ok;
		logic [15:0] temp;
	} bsc_side_t;

endpackage

FILE: src/bsc_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div_pipe
// Pipelined unsigned restoring divider, STEP_BITS quotient bits per stage.
// ----------------------------------------------------------------------------
module bsc_div_pipe #(
	parameter int STEP_BITS = bsc_pkg::DIV_STEP_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic [bsc_pkg::DIV_NUM_W-1:0]    num,
	input  logic [bsc_pkg::DIV_DEN_W-1:0]    den,
	input  bsc_pkg::bsc_side_t               in_side,
	output logic                             out_vld,
	output logic [bsc_pkg::DIV_NUM_W-1:0]    quot,
	output bsc_pkg::bsc_side_t               out_side
);
	localparam int NUM_W  = bsc_pkg::DIV_NUM_W;
	localparam int DEN_W  = bsc_pkg::DIV_DEN_W;
	localparam int STAGES = NUM_W / STEP_BITS;

	logic [NUM_W-1:0]   nq_s   [STAGES];
	logic [DEN_W-1:0]   rem_s  [STAGES];
	logic [DEN_W-1:0]   den_s  [STAGES];
	bsc_pkg::bsc_side_t side_s [STAGES];
	logic [STAGES-1:0]  vld_s;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [NUM_W-1:0]   nq_in;
		logic [DEN_W-1:0]   rem_in;
		logic [DEN_W-1:0]   den_in;
		bsc_pkg::bsc_side_t side_in;
		logic               vld_in;
		logic [NUM_W-1:0]   nq_nx;
		logic [DEN_W-1:0]   rem_nx;

		if (k == 0) begin : g_first
			assign nq_in   = num;
			assign rem_in  = '0;
			assign den_in  = den;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign nq_in   = nq_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// shift in numerator bits from the top, quotient bits at the bottom
		always_comb begin : p_step
			logic [DEN_W-1:0] r;
			logic [NUM_W-1:0] w;
			logic [DEN_W:0]   t;
			r = rem_in;
			w = nq_in;
			for (int i = 0; i < STEP_BITS; i++) begin
				t = {r, w[NUM_W-1]};
				w = {w[NUM_W-2:0], 1'b0};
				if (t >= {1'b0, den_in}) begin
					t    = t - {1'b0, den_in};
					w[0] = 1'b1;
				end
				r = t[DEN_W-1:0];
			end
			nq_nx  = w;
			rem_nx = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k]   <= nq_nx;
				rem_s[k]  <= rem_nx;
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[STAGES-1];
	assign quot     = nq_s[STAGES-1];
	assign out_side = side_s[STAGES-1];

endmodule

FILE: src/baro_sensor_compensation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_top
// Temperature and pressure compensation of raw 20-bit conversions with
// twelve packed calibration coefficients, fully pipelined.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------------
//   in        in_valid / in_stall    raw_temperature, raw_pressure
//   out       out_valid / out_stall  temperature_centi, pressure_q24_8,
//                                    pressure_valid
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle while the output is not stalled. Each stage holds
// about one level of multipliers or one 64-bit add, and the divider retires
// DIV_STEP_BITS quotient bits per stage.
// Reset clears the valid bits and the calibration registers.
// A stalled result freezes the whole pipeline in place; in_stall follows
// out_stall while a result is waiting, so nothing is lost or repeated.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_top #(
	parameter int DIV_STEP_BITS = bsc_pkg::DIV_STEP_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [19:0]                     raw_temperature,
	input  logic [19:0]                     raw_pressure,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [15:0]              temperature_centi,
	output logic [24:0]                     pressure_q24_8,
	output logic                            pressure_valid,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// ---------------- calibration registers ----------------
	logic [bsc_pkg::CFG_DATA_W-1:0] temp_cal_q, press_cal_a_q, press_cal_b_q, press_cal_c_q;

	assign cfg_ready = 1'b1;

	// decode the write; indexes beyond the list fall through and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q    <= '0;
			press_cal_a_q <= '0;
			press_cal_b_q <= '0;
			press_cal_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsc_pkg::REG_TEMP_CAL:    temp_cal_q    <= cfg_data;
				bsc_pkg::REG_PRESS_CAL_A: press_cal_a_q <= cfg_data;
				bsc_pkg::REG_PRESS_CAL_B: press_cal_b_q <= cfg_data;
				bsc_pkg::REG_PRESS_CAL_C: press_cal_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient fields; change registers only in an empty pipeline, unchecked
	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_cal_q[15:0];
	assign t2 = temp_cal_q[31:16];
	assign t3 = temp_cal_q[47:32];
	assign p1 = press_cal_a_q[15:0];
	assign p2 = press_cal_a_q[31:16];
	assign p3 = press_cal_a_q[47:32];
	assign p4 = press_cal_b_q[15:0];
	assign p5 = press_cal_b_q[31:16];
	assign p6 = press_cal_b_q[47:32];
	assign p7 = press_cal_c_q[15:0];
	assign p8 = press_cal_c_q[31:16];
	assign p9 = press_cal_c_q[47:32];

	// ---------------- flow control ----------------
	// Advance every stage together unless a result sits stalled at the output.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// valid bits of the top-level stages
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, out_valid_q;
	logic vld_div;

	// ---------------- s1: temperature differences and products ----------------
	logic signed [17:0] d1;
	logic signed [16:0] d2;
	logic signed [33:0] prod1, sq;
	assign d1    = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign d2    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
	assign prod1 = d1 * t2;
	assign sq    = d2 * d2;

	logic signed [33:0] prod1_s1, sq_s1;
	logic [19:0]        adcp_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			prod1_s1 <= prod1;
			sq_s1    <= sq;
			adcp_s1  <= raw_pressure;
		end
	end

	// ---------------- s2: second-order temperature term ----------------
	logic signed [21:0] sqs;
	logic signed [37:0] x2p;
	assign sqs = sq_s1[33:12];
	assign x2p = sqs * t3;

	logic signed [22:0] x1t_s2;
	logic signed [37:0] x2p_s2;
	logic [19:0]        adcp_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			x1t_s2  <= prod1_s1[33:11];
			x2p_s2  <= x2p;
			adcp_s2 <= adcp_s1;
		end
	end

	// ---------------- s3: fine temperature ----------------
	logic signed [23:0] x2s;
	logic signed [24:0] fine;
	logic signed [25:0] xp;
	logic signed [27:0] t5;
	assign x2s  = x2p_s2[37:14];
	assign fine = 25'(x1t_s2) + 25'(x2s);
	assign xp   = 26'(fine) - 26'(bsc_pkg::FINE_OFFSET);
	assign t5   = 28'(fine) * 28'(bsc_pkg::TEMP_SCALE) + 28'(bsc_pkg::TEMP_ROUND);

	logic signed [25:0] xp_s3;
	logic signed [19:0] tc_s3;
	logic [19:0]        adcp_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s3   <= xp;
			tc_s3   <= t5[27:8];
			adcp_s3 <= adcp_s2;
		end
	end

	// ---------------- s4: square of the offset term, temperature clamp -------
	logic signed [51:0] xx;
	logic signed [41:0] xp5, xp2;
	logic [15:0]        temp_sat;
	assign xx  = xp_s3 * xp_s3;
	assign xp5 = xp_s3 * p5;
	assign xp2 = xp_s3 * p2;

	always_comb begin
		if (tc_s3 < 20'(bsc_pkg::TEMP_MIN)) begin
			temp_sat = 16'(bsc_pkg::TEMP_MIN);
		end else if (tc_s3 > 20'(bsc_pkg::TEMP_MAX)) begin
			temp_sat = 16'(bsc_pkg::TEMP_MAX);
		end else begin
			temp_sat = tc_s3[15:0];
		end
	end

	logic signed [51:0] xx_s4;
	logic signed [41:0] xp5_s4, xp2_s4;
	logic [15:0]        temp_s4;
	logic [19:0]        adcp_s4;
	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s4   <= xx;
			xp5_s4  <= xp5;
			xp2_s4  <= xp2;
			temp_s4 <= temp_sat;
			adcp_s4 <= adcp_s3;
		end
	end

	// ---------------- s5: square times P6 and P3, wrapping at 64 bits -------
	logic signed [63:0] x2a, x1a;
	assign x2a = xx_s4 * p6;
	assign x1a = xx_s4 * p3;

	logic signed [63:0] x2a_s5, x1a_s5;
	logic signed [41:0] xp5_s5, xp2_s5;
	logic [15:0]        temp_s5;
	logic [19:0]        adcp_s5;
	always_ff @(posedge clk) begin
		if (adv) begin
			x2a_s5  <= x2a;
			x1a_s5  <= x1a;
			xp5_s5  <= xp5_s4;
			xp2_s5  <= xp2_s4;
			temp_s5 <= temp_s4;
			adcp_s5 <= adcp_s4;
		end
	end

	// ---------------- s6: sum the polynomial terms ----------------
	logic signed [63:0] x2, x1b;
	assign x2  = x2a_s5 + (64'(xp5_s5) <<< 17) + (64'(p4) <<< 35);
	assign x1b = (x1a_s5 >>> 8) + (64'(xp2_s5) <<< 12);

	logic signed [63:0] x2_s6, x1b_s6;
	logic [15:0]        temp_s6;
	logic [19:0]        adcp_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			x2_s6   <= x2;
			x1b_s6  <= x1b;
			temp_s6 <= temp_s5;
			adcp_s6 <= adcp_s5;
		end
	end

	// ---------------- s7: divisor and raw numerator ----------------
	logic [63:0] dprod, num0;
	logic [20:0] pbase;
	assign dprod = (x1b_s6 + bsc_pkg::DEN_BIAS) * 64'(p1);
	assign pbase = 21'(bsc_pkg::PRESS_BASE) - {1'b0, adcp_s6};
	assign num0  = ({43'd0, pbase} << 31) - x2_s6;

	logic [30:0] den_s7;
	logic [63:0] num0_s7;
	logic [15:0] temp_s7;
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s7  <= dprod[63:33];
			num0_s7 <= num0;
			temp_s7 <= temp_s6;
		end
	end

	// ---------------- s8: scale the numerator ----------------
	logic [30:0] den_s8;
	logic [63:0] num_s8;
	logic [15:0] temp_s8;
	always_ff @(posedge clk) begin
		if (adv) begin
			den_s8  <= den_s7;
			num_s8  <= num0_s7 * 64'(bsc_pkg::PRESS_SCALE);
			temp_s8 <= temp_s7;
		end
	end

	// ---------------- s9: magnitudes and quotient sign ----------------
	logic [63:0]        ma_s9;
	logic [30:0]        mb_s9;
	bsc_pkg::bsc_side_t side_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s9          <= num_s8[63] ? (64'd0 - num_s8) : num_s8;
			mb_s9          <= den_s8[30] ? (31'd0 - den_s8) : den_s8;
			side_s9.neg    <= num_s8[63] ^ den_s8[30];
			side_s9.div_ok <= (den_s8 != 31'd0);
			side_s9.temp   <= temp_s8;
		end
	end

	// ---------------- divider ----------------
	logic [63:0]        qm;
	bsc_pkg::bsc_side_t side_div;

	bsc_div_pipe #(
		.STEP_BITS (DIV_STEP_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s9),
		.num      (ma_s9),
		.den      (mb_s9),
		.in_side  (side_s9),
		.out_vld  (vld_div),
		.quot     (qm),
		.out_side (side_div)
	);

	// ---------------- s10: apply the quotient sign ----------------
	logic signed [63:0] q_s10;
	bsc_pkg::bsc_side_t side_s10;
	always_ff @(posedge clk) begin
		if (adv) begin
			q_s10    <= side_div.neg ? (64'd0 - qm) : qm;
			side_s10 <= side_div;
		end
	end

	// ---------------- s11: partial products of (p >> 13)^2, P8 term --------
	logic signed [63:0] s64, b0;
	logic [31:0]        sl, shx, pm;
	logic [63:0]        pll;
	assign s64 = q_s10 >>> 13;
	assign sl  = s64[31:0];
	assign shx = s64[63:32];
	assign pll = 64'(sl) * 64'(sl);
	assign pm  = sl * shx;
	assign b0  = q_s10 * p8;

	logic [63:0]        pll_s11;
	logic [31:0]        pm_s11;
	logic signed [63:0] b0_s11, q_s11;
	bsc_pkg::bsc_side_t side_s11;
	always_ff @(posedge clk) begin
		if (adv) begin
			pll_s11  <= pll;
			pm_s11   <= pm;
			b0_s11   <= b0;
			q_s11    <= q_s10;
			side_s11 <= side_s10;
		end
	end

	// ---------------- s12: combine the square, shift the P8 term -----------
	logic signed [63:0] ss_s12, b_s12, q_s12;
	bsc_pkg::bsc_side_t side_s12;
	always_ff @(posedge clk) begin
		if (adv) begin
			ss_s12   <= pll_s11 + {pm_s11[30:0], 33'd0};
			b_s12    <= b0_s11 >>> 19;
			q_s12    <= q_s11;
			side_s12 <= side_s11;
		end
	end

	// ---------------- s13: square times P9 ----------------
	logic signed [63:0] a0;
	assign a0 = ss_s12 * p9;

	logic signed [63:0] a0_s13, b_s13, q_s13;
	bsc_pkg::bsc_side_t side_s13;
	always_ff @(posedge clk) begin
		if (adv) begin
			a0_s13   <= a0;
			b_s13    <= b_s12;
			q_s13    <= q_s12;
			side_s13 <= side_s12;
		end
	end

	// ---------------- s14: correction sum ----------------
	logic signed [63:0] sum_s14;
	bsc_pkg::bsc_side_t side_s14;
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s14  <= q_s13 + (a0_s13 >>> 25) + b_s13;
			side_s14 <= side_s13;
		end
	end

	// ---------------- output: offset, clamp, zero-divisor drop ----------------
	logic signed [63:0] pr;
	logic [24:0]        press_sat;
	assign pr = (sum_s14 >>> 8) + (64'(p7) <<< 4);

	always_comb begin
		if (!side_s14.div_ok || pr < 64'sd0) begin
			press_sat = '0;
		end else if (pr > 64'(bsc_pkg::PRESS_MAX)) begin
			press_sat = 25'(bsc_pkg::PRESS_MAX);
		end else begin
			press_sat = pr[24:0];
		end
	end

	logic [15:0] temp_q;
	logic [24:0] press_q;
	logic        pvalid_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			temp_q   <= side_s14.temp;
			press_q  <= press_sat;
			pvalid_q <= side_s14.div_ok;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature_centi = temp_q;
	assign pressure_q24_8    = press_q;
	assign pressure_valid    = pvalid_q;

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			vld_s10     <= 1'b0;
			vld_s11     <= 1'b0;
			vld_s12     <= 1'b0;
			vld_s13     <= 1'b0;
			vld_s14     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			vld_s8      <= vld_s7;
			vld_s9      <= vld_s8;
			vld_s10     <= vld_div;
			vld_s11     <= vld_s10;
			vld_s12     <= vld_s11;
			vld_s13     <= vld_s12;
			vld_s14     <= vld_s13;
			out_valid_q <= vld_s14;
		end
	end

	// ---------------- assertions ----------------
	// a dropped pressure always reads as zero
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pressure_valid |-> pressure_q24_8 == 25'd0)
		else $error("pressure not zero on zero divisor");

	// no input is taken while a result is held at the output
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input accepted during output stall");

	// a frozen pipeline keeps the valid bits of stages s1 and s14
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(vld_s14))
		else $error("pipeline moved while stalled");

endmodule
